// ===== rtl/sta_pkg.sv =====
package sta_pkg;

    // operation codes
    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_PUT      = 3'd1;
    localparam logic [2:0] OP_GET      = 3'd2;
    localparam logic [2:0] OP_IS_VALID = 3'd3;
    localparam logic [2:0] OP_REMOVE   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BLK,
        S_SCAN_BLK,
        S_STORE,
        S_SCAN_LF,
        S_SCAN_HV,
        S_READ,
        S_DONE
    } ctl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       capture;
        logic       set_status;
        logic [1:0] status_code;
        logic       grow;
        logic       mark_block;
        logic       lf_step;
        logic       siu_inc;
        logic       store;
        logic       remove;
        logic       hv_step;
        logic       rd_data;
        logic       rd_valid;
        logic       take_read;
        logic       load_out;
    } sta_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_add;
        logic is_put;
        logic is_get;
        logic is_valid_op;
        logic is_remove;
        logic in_range;
        logic full;
        logic grow;
        logic block;
        logic idx_is_lf;
        logic rm_hv;
        logic hv_is_one;
        logic lf_cont;
        logic q_valid;
        logic out_free;
    } sta_sts_t;

endpackage

// ===== rtl/sta_ram.sv =====
module sta_ram
    import sta_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1026
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sta_ctrl.sv =====
module sta_ctrl
    import sta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  sta_sts_t sts,
    output sta_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.is_add)
                begin
                    if (sts.full)
                        state_next = S_DONE;
                    else if (sts.block)
                        state_next = S_BLK;
                    else
                        state_next = S_STORE;
                end
                else if (sts.is_put)
                begin
                    state_next = (sts.in_range && sts.idx_is_lf) ? S_SCAN_LF : S_DONE;
                end
                else if (sts.is_get || sts.is_valid_op)
                begin
                    state_next = sts.in_range ? S_READ : S_DONE;
                end
                else if (sts.is_remove)
                begin
                    state_next = (sts.in_range && sts.rm_hv && !sts.hv_is_one)
                                 ? S_SCAN_HV : S_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BLK:
            begin
                state_next = S_SCAN_BLK;
            end
            S_SCAN_BLK:
            begin
                if (!sts.lf_cont)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                state_next = S_SCAN_LF;
            end
            S_SCAN_LF:
            begin
                if (!sts.lf_cont)
                    state_next = S_DONE;
            end
            S_SCAN_HV:
            begin
                if (sts.q_valid || sts.hv_is_one)
                    state_next = S_DONE;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        cmd.status_code = STAT_OK;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
            end
            S_DISPATCH:
            begin
                if (sts.is_add)
                begin
                    if (sts.full)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_FULL;
                    end
                    else
                    begin
                        cmd.grow = sts.grow;
                    end
                end
                else if (sts.is_put || sts.is_get || sts.is_valid_op || sts.is_remove)
                begin
                    if (!sts.in_range)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_RANGE;
                    end
                    else if (sts.is_put)
                    begin
                        cmd.store   = 1'b1;
                        cmd.lf_step = sts.idx_is_lf;
                    end
                    else if (sts.is_get)
                    begin
                        cmd.rd_data = 1'b1;
                    end
                    else if (sts.is_valid_op)
                    begin
                        cmd.rd_valid = 1'b1;
                    end
                    else
                    begin
                        cmd.remove  = 1'b1;
                        cmd.hv_step = sts.rm_hv;
                    end
                end
            end
            S_BLK:
            begin
                cmd.mark_block = 1'b1;
                cmd.lf_step    = 1'b1;
            end
            S_SCAN_BLK:
            begin
                cmd.lf_step = sts.lf_cont;
                cmd.siu_inc = !sts.lf_cont;
            end
            S_STORE:
            begin
                cmd.store   = 1'b1;
                cmd.lf_step = 1'b1;
            end
            S_SCAN_LF:
            begin
                cmd.lf_step = sts.lf_cont;
            end
            S_SCAN_HV:
            begin
                cmd.hv_step = !sts.q_valid;
            end
            S_READ:
            begin
                cmd.take_read = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/sta_datapath.sv =====
module sta_datapath
    import sta_pkg::*;
#(
    parameter int SLOTS      = 1024,
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sta_cmd_t              cmd,
    output sta_sts_t              sts,
    input  logic [2:0]            opcode,
    input  logic [IDX_W-1:0]      slot_index,
    input  logic [DATA_WIDTH-1:0] write_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      given_index,
    output logic [DATA_WIDTH-1:0] read_data,
    output logic                  slot_valid,
    output logic [1:0]            status
);

    localparam int DEPTH = SLOTS + 2;

    // captured word
    logic [2:0]            op_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [DATA_WIDTH-1:0] wd_reg;

    // table bookkeeping
    logic [IDX_W-1:0] lf_reg;
    logic [IDX_W-1:0] hv_reg;
    logic [IDX_W-1:0] siu_reg;
    logic [IDX_W-1:0] lg_reg;

    // pending result
    logic [IDX_W-1:0]      given_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  sv_reg;
    logic [1:0]            status_reg;

    // output register
    logic                  out_valid_reg;
    logic [IDX_W-1:0]      out_given_reg;
    logic [DATA_WIDTH-1:0] out_rdata_reg;
    logic                  out_sv_reg;
    logic [1:0]            out_status_reg;

    // memory ports
    logic                  v_we;
    logic [IDX_W-1:0]      v_waddr;
    logic                  v_wdata;
    logic                  v_re;
    logic [IDX_W-1:0]      v_raddr;
    logic                  v_q;
    logic [DATA_WIDTH-1:0] d_q;

    logic                  is_add;
    logic [IDX_W-1:0]      pick;
    logic [IDX_W-1:0]      siu_plus1;
    logic [IDX_W:0]        need;

    assign is_add    = (op_reg == OP_ADD);
    assign pick      = is_add ? lf_reg : idx_reg;
    assign siu_plus1 = siu_reg + IDX_W'(1);
    assign need      = {1'b0, siu_reg} + (IDX_W+1)'(lf_reg > siu_reg)
                       + (IDX_W+1)'(lf_reg == lg_reg);

    // status toward the controller
    always_comb
    begin
        sts.is_add      = is_add;
        sts.is_put      = (op_reg == OP_PUT);
        sts.is_get      = (op_reg == OP_GET);
        sts.is_valid_op = (op_reg == OP_IS_VALID);
        sts.is_remove   = (op_reg == OP_REMOVE);
        sts.in_range    = (idx_reg != '0) && (idx_reg <= siu_reg);
        sts.full        = (need > (IDX_W+1)'(SLOTS));
        sts.grow        = (lf_reg > siu_reg);
        sts.block       = (lf_reg == lg_reg);
        sts.idx_is_lf   = (idx_reg == lf_reg);
        sts.rm_hv       = (idx_reg == hv_reg);
        sts.hv_is_one   = (hv_reg == IDX_W'(1));
        // slots above the fill count read as empty
        sts.lf_cont     = (lf_reg <= siu_reg) && v_q;
        sts.q_valid     = v_q;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    // valid bit memory port selection
    always_comb
    begin
        v_we    = 1'b0;
        v_waddr = pick;
        v_wdata = 1'b0;
        if (cmd.grow || cmd.siu_inc)
        begin
            v_we    = 1'b1;
            v_waddr = siu_plus1;
            v_wdata = 1'b0;
        end
        else if (cmd.mark_block)
        begin
            v_we    = 1'b1;
            v_waddr = lg_reg;
            v_wdata = 1'b1;
        end
        else if (cmd.store)
        begin
            v_we    = 1'b1;
            v_waddr = pick;
            v_wdata = 1'b1;
        end
        else if (cmd.remove)
        begin
            v_we    = 1'b1;
            v_waddr = idx_reg;
            v_wdata = 1'b0;
        end
    end

    always_comb
    begin
        v_re    = cmd.lf_step || cmd.hv_step || cmd.rd_valid;
        v_raddr = idx_reg;
        if (cmd.lf_step)
            v_raddr = lf_reg + IDX_W'(1);
        else if (cmd.hv_step)
            v_raddr = hv_reg - IDX_W'(1);
    end

    sta_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_valid_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (v_q)
    );

    sta_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (pick),
        .wdata (wd_reg),
        .re    (cmd.rd_data),
        .raddr (idx_reg),
        .rdata (d_q)
    );

    // table counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lf_reg  <= IDX_W'(1);
            hv_reg  <= '0;
            siu_reg <= '0;
            lg_reg  <= '0;
        end
        else
        begin
            if (cmd.grow || cmd.siu_inc)
                siu_reg <= siu_plus1;
            if (cmd.lf_step)
                lf_reg <= lf_reg + IDX_W'(1);
            else if (cmd.remove && (idx_reg < lf_reg))
                lf_reg <= idx_reg;
            if (cmd.mark_block && (hv_reg < lg_reg))
                hv_reg <= lg_reg;
            else if (cmd.store && (hv_reg < pick))
                hv_reg <= pick;
            else if (cmd.hv_step)
                hv_reg <= hv_reg - IDX_W'(1);
            if (cmd.store && is_add)
                lg_reg <= lf_reg;
        end
    end

    // captured word and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode;
            idx_reg    <= slot_index;
            wd_reg     <= write_data;
            given_reg  <= '0;
            rdata_reg  <= '0;
            sv_reg     <= 1'b0;
            status_reg <= STAT_OK;
        end
        else
        begin
            if (cmd.set_status)
                status_reg <= cmd.status_code;
            if (cmd.store && is_add)
                given_reg <= lf_reg;
            if (cmd.take_read)
            begin
                rdata_reg <= (op_reg == OP_GET) ? d_q : '0;
                sv_reg    <= (op_reg == OP_IS_VALID) ? v_q : 1'b0;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_given_reg  <= given_reg;
            out_rdata_reg  <= rdata_reg;
            out_sv_reg     <= sv_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign given_index = out_given_reg;
    assign read_data   = out_rdata_reg;
    assign slot_valid  = out_sv_reg;
    assign status      = out_status_reg;

endmodule

// ===== rtl/slot_table_allocator_core.sv =====
// flow: get and is_valid go from dispatch through read to done; put, remove and add go from
//   dispatch through the block, store, free-slot scan or highest-valid scan states to done
// throughput: one word at a time, the next word is accepted once the result is loaded into the
//   output register; the scans read one valid bit per cycle from the valid ram and set the item time
// reset: asynchronous, active low; valid bits read as clear through the fill count, so no
//   clearing pass is needed and words are accepted right after reset
module slot_table_allocator_core
    import sta_pkg::*;
#(
    parameter int SLOTS      = 1024,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W     = $clog2(SLOTS + 2)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            opcode,
    input  logic [IDX_W-1:0]      slot_index,
    input  logic [DATA_WIDTH-1:0] write_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      given_index,
    output logic [DATA_WIDTH-1:0] read_data,
    output logic                  slot_valid,
    output logic [1:0]            status
);

    sta_cmd_t cmd;
    sta_sts_t sts;

    sta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sta_datapath #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (opcode),
        .slot_index  (slot_index),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .given_index (given_index),
        .read_data   (read_data),
        .slot_valid  (slot_valid),
        .status      (status)
    );

    // result loads only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
    else $error("result loaded into occupied output register");

    // an accepted word blocks the input until its result is handed over
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in flight");

    // capture and result load never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !cmd.load_out)
    else $error("capture and output load in the same cycle");

    // a nonzero slot number only comes with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (given_index == '0 || status == STAT_OK))
    else $error("slot number given with error status");

endmodule

// ===== bench/slot_table_allocator_core_test.sv =====
module slot_table_allocator_core_test;
    import sta_pkg::*;

    localparam int SLOTS        = 1024;
    localparam int DATA_WIDTH   = 32;
    localparam int IDX_W        = $clog2(SLOTS + 2);
    localparam int RANDOM_WORDS = 250;
    localparam int FILL_GUARD   = 4000;
    localparam int FULL_TARGET  = 4;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_LIMIT = 10;

    // opcodes the block does not decode
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]      given;
        logic [DATA_WIDTH-1:0] rdata;
        logic                  valid;
        logic [1:0]            status;
    } reply_t;

    typedef struct packed {
        logic [2:0]            op;
        logic [IDX_W-1:0]      idx;
        logic [DATA_WIDTH-1:0] wd;
        logic                  typed;
        reply_t                want;
    } dir_row_t;

    localparam reply_t QUIET     = '0;
    localparam reply_t RANGE_ERR = '{'0, '0, 1'b0, STAT_RANGE};

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [2:0]            opcode     = OP_ADD;
    logic [IDX_W-1:0]      slot_index = '0;
    logic [DATA_WIDTH-1:0] write_data = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [IDX_W-1:0]      given_index;
    logic [DATA_WIDTH-1:0] read_data;
    logic                  slot_valid;
    logic [1:0]            status;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatches         = 0;
    int full_replies       = 0;
    int quiet_cycles       = 0;

    reply_t replies_due[$];

    // shadow copy of the slot table
    bit                    occupied   [0:SLOTS+1];
    logic [DATA_WIDTH-1:0] slot_words [1:SLOTS];
    bit                    written    [1:SLOTS];
    logic [IDX_W-1:0]      lowest_free = 1;
    logic [IDX_W-1:0]      top_valid   = 0;
    logic [IDX_W-1:0]      fill_count  = 0;
    logic [IDX_W-1:0]      prev_given  = 0;

    // opening sequence: error paths, extremes, slot reuse, repeated-slot block
    dir_row_t opening_rows [25] = '{
        '{OP_GET,      11'd1,    32'd0,           1'b1, RANGE_ERR},
        '{OP_IS_VALID, 11'd0,    32'd0,           1'b1, RANGE_ERR},
        '{OP_REMOVE,   11'd2047, 32'd0,           1'b1, RANGE_ERR},
        '{OP_PUT,      11'd1024, 32'hFFFF_FFFF,   1'b1, RANGE_ERR},
        '{OP_SPARE_LO, 11'd1,    32'hFFFF_FFFF,   1'b1, QUIET},
        '{OP_SPARE_HI, 11'd2047, 32'hFFFF_FFFF,   1'b1, QUIET},
        '{OP_ADD,      11'd0,    32'd0,           1'b1, '{11'd1, 32'd0, 1'b0, STAT_OK}},
        '{OP_ADD,      11'd2047, 32'hFFFF_FFFF,   1'b1, '{11'd2, 32'd0, 1'b0, STAT_OK}},
        '{OP_GET,      11'd1,    32'd0,           1'b1, QUIET},
        '{OP_GET,      11'd2,    32'd0,           1'b1,
          '{11'd0, 32'hFFFF_FFFF, 1'b0, STAT_OK}},
        '{OP_IS_VALID, 11'd2,    32'd0,           1'b1, '{11'd0, 32'd0, 1'b1, STAT_OK}},
        '{OP_REMOVE,   11'd1,    32'd0,           1'b0, QUIET},
        '{OP_ADD,      11'd0,    32'hA5A5_A5A5,   1'b0, QUIET},
        '{OP_REMOVE,   11'd1,    32'd0,           1'b0, QUIET},
        '{OP_ADD,      11'd0,    32'h5A5A_5A5A,   1'b0, QUIET},
        '{OP_IS_VALID, 11'd1,    32'd0,           1'b0, QUIET},
        '{OP_REMOVE,   11'd3,    32'd0,           1'b0, QUIET},
        '{OP_REMOVE,   11'd2,    32'd0,           1'b0, QUIET},
        '{OP_REMOVE,   11'd1,    32'd0,           1'b0, QUIET},
        '{OP_IS_VALID, 11'd1,    32'd0,           1'b0, QUIET},
        '{OP_PUT,      11'd3,    32'h1234_5678,   1'b0, QUIET},
        '{OP_GET,      11'd3,    32'd0,           1'b0, QUIET},
        '{OP_GET,      11'd4,    32'd0,           1'b1, RANGE_ERR},
        '{OP_PUT,      11'd0,    32'h0000_0001,   1'b1, RANGE_ERR},
        '{OP_IS_VALID, 11'd2047, 32'd0,           1'b1, RANGE_ERR}
    };

    slot_table_allocator_core #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .slot_index  (slot_index),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .given_index (given_index),
        .read_data   (read_data),
        .slot_valid  (slot_valid),
        .status      (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // valid bits outside the table read as clear
    function automatic bit occupied_at(input int unsigned i);
        if (i == 0 || i > SLOTS)
            return 1'b0;
        return occupied[i];
    endfunction

    // move lowest free past the filled slots, raise the top mark
    function automatic void advance_marks(input int unsigned n);
        bit v;
        if (n == lowest_free)
        begin
            do
            begin
                lowest_free = lowest_free + 1'b1;
                v = occupied_at(lowest_free);
            end
            while (lowest_free <= fill_count && v);
        end
        if (top_valid < n)
            top_valid = IDX_W'(n);
    endfunction

    function automatic void occupy_slot(input int unsigned n, input logic [DATA_WIDTH-1:0] d);
        advance_marks(n);
        if (n >= 1 && n <= SLOTS)
        begin
            occupied[n]   = 1'b1;
            slot_words[n] = d;
            written[n]    = 1'b1;
        end
    endfunction

    // table behavior for one accepted word
    function automatic reply_t model_word(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                          input logic [DATA_WIDTH-1:0] wd);
        reply_t      r;
        bit          grow;
        bit          blocked;
        int unsigned need;
        bit          v;
        r = '0;
        case (op)
            OP_ADD:
            begin
                grow    = lowest_free > fill_count;
                blocked = lowest_free == prev_given;
                need    = int'(fill_count) + int'(grow) + int'(blocked);
                if (need > SLOTS)
                    r.status = STAT_FULL;
                else
                begin
                    if (grow)
                    begin
                        fill_count = fill_count + 1'b1;
                        occupied[fill_count] = 1'b0;
                    end
                    // same slot as the previous add: block it and move on
                    if (blocked)
                    begin
                        occupied[prev_given] = 1'b1;
                        advance_marks(prev_given);
                        fill_count = fill_count + 1'b1;
                    end
                    prev_given = lowest_free;
                    occupy_slot(prev_given, wd);
                    r.given = prev_given;
                end
            end
            OP_PUT, OP_GET, OP_IS_VALID, OP_REMOVE:
            begin
                if (idx == 0 || idx > fill_count)
                    r.status = STAT_RANGE;
                else
                begin
                    case (op)
                        OP_PUT:      occupy_slot(idx, wd);
                        OP_GET:      r.rdata = slot_words[idx];
                        OP_IS_VALID: r.valid = occupied[idx];
                        default:
                        begin
                            occupied[idx] = 1'b0;
                            if (idx < lowest_free)
                                lowest_free = idx;
                            // top mark walks down, never reading slot zero
                            if (idx == top_valid)
                            begin
                                do
                                begin
                                    top_valid = top_valid - 1'b1;
                                    v = occupied_at(top_valid);
                                end
                                while (top_valid > 0 && !v);
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void set_idling(input int phase);
        case (phase % 4)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
            default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
        endcase
    endfunction

    // mostly live slots, with the edges and the full index range mixed in
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned roll;
        int unsigned upper;
        roll  = $urandom_range(99);
        upper = (fill_count == 0) ? 1 : fill_count;
        if (roll < 5)
            return '0;
        if (roll < 12)
            return IDX_W'($urandom_range(2**IDX_W - 1));
        if (roll < 20)
            return top_valid;
        if (roll < 26)
            return fill_count + 1'b1;
        return IDX_W'($urandom_range(upper, 1));
    endfunction

    // drive one word, wait for the handshake, record what should come back
    task automatic send_word(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                             input logic [DATA_WIDTH-1:0] wd, input bit typed,
                             input reply_t want);
        reply_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        slot_index <= idx;
        write_data <= wd;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = model_word(op, idx, wd);
        if (predicted.status == STAT_FULL)
            full_replies++;
        replies_due.push_back(typed ? want : predicted);
    endtask

    task automatic send_random(input bit fill_bias);
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
        int unsigned      roll;
        roll = $urandom_range(99);
        if (fill_bias && roll < 85)
            op = OP_ADD;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                op = OP_ADD;
            else if (roll < 45)
                op = OP_PUT;
            else if (roll < 65)
                op = OP_GET;
            else if (roll < 78)
                op = OP_IS_VALID;
            else if (roll < 95)
                op = OP_REMOVE;
            else
                op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        idx = pick_index();
        // never read data that was not stored yet
        if (op == OP_GET && idx >= 1 && idx <= fill_count && !written[idx])
            op = OP_IS_VALID;
        send_word(op, idx, $urandom(), 1'b0, QUIET);
    endtask

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin : check_replies
        reply_t got;
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{given_index, read_data, slot_valid, status};
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: given %0d data %h valid %0b status %0d",
                             got.given, got.rdata, got.valid, got.status);
            end
            else
            begin
                want = replies_due.pop_front();
                if (got.given !== want.given || got.rdata !== want.rdata ||
                    got.valid !== want.valid || got.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: expected given %0d data %h valid %0b status %0d, %s",
                                 want.given, want.rdata, want.valid, want.status,
                                 $sformatf("got given %0d data %h valid %0b status %0d",
                                           got.given, got.rdata, got.valid, got.status));
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int step;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0);
        foreach (opening_rows[i])
            send_word(opening_rows[i].op, opening_rows[i].idx, opening_rows[i].wd,
                      opening_rows[i].typed, opening_rows[i].want);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 125 == 0)
                set_idling(i / 125);
            send_random(1'b0);
        end

        // mostly adds until the table reports full a few times
        step = 0;
        while (full_replies < FULL_TARGET && step < FILL_GUARD)
        begin
            if (step % 125 == 0)
                set_idling(step / 125);
            send_random(1'b1);
            step++;
        end

        // mixed traffic on a full table
        set_idling(3);
        for (int i = 0; i < 60; i++)
            send_random(1'b0);

        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += replies_due.size();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
